// ===== src/kefq_pkg.sv =====
// kefq_pkg: widths and shared types of the quick-find edge filter
// used by the top level and the checker; depends on nothing

package kefq_pkg;

    localparam int CFG_W = 9;
    localparam int VTX_W = 8;
    localparam int LEN_W = 16;
    localparam int IN_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    localparam logic [CFG_W-1:0] VCOUNT_RESET = 9'd256;

    typedef logic [VTX_W-1:0] vertex_t;
    typedef logic [LEN_W-1:0] length_t;

endpackage

// ===== src/kefq_cell.sv =====
// kefq_cell: one label register of the rotating label ring
// no package needed; reset value set by the cell's position

module kefq_cell #(
    parameter int LW = 8,
    parameter int INDEX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic [LW-1:0] din,
    output logic [LW-1:0] q
);

    logic [LW-1:0] label_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= LW'(INDEX);
        end
        else if (shift)
        begin
            label_reg <= din;
        end
    end

    assign q = label_reg;

endmodule

// ===== src/kefq_ring.sv =====
// kefq_ring: row of label cells rotating toward cell 0
// depends on kefq_cell; the head value is modified outside and fed back in

module kefq_ring #(
    parameter int N = 256,
    parameter int LW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic [LW-1:0] head_in,
    output logic [LW-1:0] head_out
);

    logic [LW-1:0] q [N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [LW-1:0] din;
        if (i == N - 1)
        begin : g_tail
            assign din = head_in;
        end
        else
        begin : g_mid
            assign din = q[i+1];
        end
        kefq_cell #(
            .LW    (LW),
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (din),
            .q     (q[i])
        );
    end

    assign head_out = q[0];

endmodule

// ===== src/kruskal_edge_filter_quick_find.sv =====
// kruskal_edge_filter_quick_find: top level, sequencer around the label ring
// depends on kefq_pkg, kefq_ring and kefq_cell
// an edge taken in is looked up in a full rotation of the label ring; the word of a rejected or
// bad edge is written after that rotation, that of an accepted one after a second full rotation
// (a lookup pass, then a relabel pass only when the edge joins two components), each once the
// output register is free; one edge at a time, the next taken only after that word is written;
// a finished word waits in the output register while the next edge is taken
// reset (rst_n low, asynchronous) restores every label to its index, count to 256

module kruskal_edge_filter_quick_find #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kefq_pkg::CFG_W-1:0]          cfg_data,      // vertex_count
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [kefq_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // vertex_a, vertex_b, edge_length
    input  logic [0:0]                          s_axis_tuser,  // new_graph
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kefq_pkg::IN_DATA_W-1:0]      m_axis_tdata,  // out_vertex_a, out_vertex_b, out_length
    output logic [kefq_pkg::OUT_USER_W-1:0]     m_axis_tuser   // accepted, bad_vertex
);

    import kefq_pkg::*;

    localparam int LW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [CMPW-1:0] MAXV = CMPW'(MAX_VERTICES);
    localparam logic [LW-1:0] LAST_POS = LW'(MAX_VERTICES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LW-1:0]    pos_reg, pos_next;
    logic [CFG_W-1:0] vcount_reg, vcount_next;
    logic             m_valid_reg, m_valid_next;
    logic             acc_reg, acc_next;

    vertex_t          a_reg, a_next;
    vertex_t          b_reg, b_next;
    length_t          len_reg, len_next;
    logic             fresh_reg, fresh_next;
    logic             bad_reg, bad_next;
    logic [LW-1:0]    keep_reg, keep_next;
    logic [LW-1:0]    gone_reg, gone_next;
    logic [IN_DATA_W-1:0]  odata_reg, odata_next;
    logic [OUT_USER_W-1:0] ouser_reg, ouser_next;

    logic [CMPW-1:0]  cnt_eff;
    logic [CMPW-1:0]  pos_ext;
    logic [LW-1:0]    head_q, head_d;
    logic             shift;
    vertex_t          in_a, in_b;

    kefq_ring #(
        .N  (MAX_VERTICES),
        .LW (LW)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .head_in  (head_d),
        .head_out (head_q)
    );

    assign in_a = s_axis_tdata[VTX_W-1:0];
    assign in_b = s_axis_tdata[2*VTX_W-1:VTX_W];
    assign cnt_eff = (CMPW'(vcount_reg) > MAXV) ? MAXV : CMPW'(vcount_reg);
    assign pos_ext = CMPW'(pos_reg);
    assign shift = (state_reg == ST_FIND) || (state_reg == ST_FIX);

    // head of the ring holds the label of vertex pos_reg
    always_comb
    begin
        unique case (state_reg)
            ST_FIND: head_d = fresh_reg ? pos_reg : head_q;
            ST_FIX:  head_d = ((pos_ext < cnt_eff) && (head_q == gone_reg)) ? keep_reg : head_q;
            default: head_d = head_q;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        len_next     = len_reg;
        fresh_next   = fresh_reg;
        bad_next     = bad_reg;
        keep_next    = keep_reg;
        gone_next    = gone_reg;
        odata_next   = odata_reg;
        ouser_next   = ouser_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        vcount_next  = cfg_valid ? cfg_data : vcount_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    a_next     = in_a;
                    b_next     = in_b;
                    len_next   = s_axis_tdata[IN_DATA_W-1:2*VTX_W];
                    fresh_next = s_axis_tuser[0];
                    bad_next   = (CMPW'(in_a) >= cnt_eff) || (CMPW'(in_b) >= cnt_eff);
                    pos_next   = '0;
                    acc_next   = 1'b0;
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (CMPW'(a_reg) == pos_ext)
                begin
                    keep_next = head_d;
                end
                if (CMPW'(b_reg) == pos_ext)
                begin
                    gone_next = head_d;
                end
                if (pos_reg == LAST_POS)
                begin
                    pos_next = '0;
                    if (!bad_reg && (keep_next != gone_next))
                    begin
                        acc_next   = 1'b1;
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_FIX:
            begin
                if (pos_reg == LAST_POS)
                begin
                    pos_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    odata_next   = {len_reg, b_reg, a_reg};
                    ouser_next   = {bad_reg, acc_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            acc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            vcount_reg  <= VCOUNT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            vcount_reg  <= vcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        len_reg   <= len_next;
        fresh_reg <= fresh_next;
        bad_reg   <= bad_next;
        keep_reg  <= keep_next;
        gone_reg  <= gone_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

// ===== src/kefq_checker.sv =====
// kefq_checker: port-level assertions for the quick-find edge filter
// depends on kefq_pkg; bound to kruskal_edge_filter_quick_find below

module kefq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [kefq_pkg::IN_DATA_W-1:0]  m_axis_tdata,
    input logic [kefq_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    import kefq_pkg::*;

    // one edge in flight: ready drops right after a word is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an edge is still in work");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped or changed while stalled");

    // a bad edge is never a tree edge
    a_bad_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("edge both accepted and flagged bad");

    // self loops never join components
    a_self_loop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[VTX_W-1:0] != m_axis_tdata[2*VTX_W-1:VTX_W])
        else $error("self loop accepted");

endmodule

bind kruskal_edge_filter_quick_find kefq_checker u_kefq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
